>>> design/tcpwm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tcpwm_pkg;

    localparam int MSG_MAX = 64;
    localparam int POS_W   = $clog2(MSG_MAX + 1);
    localparam int CAP_N   = 12;
    localparam int KW_N    = 13;

    localparam int K_LOCK = 0;
    localparam int K_UNL  = 1;
    localparam int K_MID  = 2;
    localparam int K_PITP = 3;
    localparam int K_PITM = 4;
    localparam int K_ROLP = 5;
    localparam int K_ROLM = 6;
    localparam int K_UPDP = 7;
    localparam int K_UPDM = 8;
    localparam int K_YAWP = 9;
    localparam int K_YAWM = 10;
    localparam int K_S    = 11;
    localparam int K_GET  = 12;

    localparam logic [31:0] KW_LOCK = "LOCK";
    localparam logic [23:0] KW_UNL  = "UNL";
    localparam logic [23:0] KW_MID  = "MID";
    localparam logic [31:0] KW_PITP = "PIT+";
    localparam logic [31:0] KW_PITM = "PIT-";
    localparam logic [31:0] KW_ROLP = "ROL+";
    localparam logic [31:0] KW_ROLM = "ROL-";
    localparam logic [31:0] KW_UPDP = "UPD+";
    localparam logic [31:0] KW_UPDM = "UPD-";
    localparam logic [31:0] KW_YAWP = "YAW+";
    localparam logic [31:0] KW_YAWM = "YAW-";
    localparam logic [7:0]  KW_S    = "s";
    localparam logic [23:0] KW_GET  = "GET";

    localparam logic [7:0] CHR_ZERO = 8'h30;
    localparam logic [7:0] CHR_PLUS = 8'h2B;
    localparam logic [7:0] CHR_NUL  = 8'h00;

    localparam logic [1:0] CH_ROLL     = 2'd0;
    localparam logic [1:0] CH_PITCH    = 2'd1;
    localparam logic [1:0] CH_THROTTLE = 2'd2;
    localparam logic [1:0] CH_YAW      = 2'd3;

    localparam logic [2:0] CFG_NEUTRAL  = 3'd0;
    localparam logic [2:0] CFG_FLOOR    = 3'd1;
    localparam logic [2:0] CFG_CEILING  = 3'd2;
    localparam logic [2:0] CFG_FINE     = 3'd3;
    localparam logic [2:0] CFG_TSTEP    = 3'd4;
    localparam logic [2:0] CFG_ARM      = 3'd5;
    localparam logic [2:0] CFG_DISARM   = 3'd6;

    localparam logic [15:0] RST_NEUTRAL = 16'd7500;
    localparam logic [15:0] RST_FLOOR   = 16'd5000;
    localparam logic [15:0] RST_CEILING = 16'd8000;
    localparam logic [15:0] RST_FINE    = 16'd5;
    localparam logic [15:0] RST_TSTEP   = 16'd50;
    localparam logic [15:0] RST_ARM     = 16'd10000;
    localparam logic [15:0] RST_DISARM  = 16'd5000;

    localparam logic [0:0] KIND_WRITE = 1'b0;
    localparam logic [0:0] KIND_REPLY = 1'b1;

    typedef enum logic [3:0] {
        ACT_NONE, ACT_LOCK, ACT_UNL, ACT_MID, ACT_PITP, ACT_PITM, ACT_ROLP,
        ACT_ROLM, ACT_UPDP, ACT_UPDM, ACT_YAWP, ACT_YAWM, ACT_SET, ACT_GET
    } t_action;

    typedef struct packed {
        t_action                  action;
        logic [CAP_N-1:0][7:0]    caps;
    } t_cmd;

    typedef struct packed {
        logic [0:0]  kind;
        logic [1:0]  chan;
        logic [15:0] width;
        logic [7:0]  reply;
        logic        last;
    } t_result;

    typedef enum logic [1:0] {RS_DIGIT, RS_PLUS, RS_NUL} t_reply_src;

    typedef struct packed {
        t_reply_src src;
        logic [1:0] chan;
        logic [1:0] pos;
    } t_get_step;

    function automatic t_action prio(input logic [KW_N-1:0] seen);
        t_action a;
        if (seen[K_LOCK])      a = ACT_LOCK;
        else if (seen[K_UNL])  a = ACT_UNL;
        else if (seen[K_MID])  a = ACT_MID;
        else if (seen[K_PITP]) a = ACT_PITP;
        else if (seen[K_PITM]) a = ACT_PITM;
        else if (seen[K_ROLP]) a = ACT_ROLP;
        else if (seen[K_ROLM]) a = ACT_ROLM;
        else if (seen[K_UPDP]) a = ACT_UPDP;
        else if (seen[K_UPDM]) a = ACT_UPDM;
        else if (seen[K_YAWP]) a = ACT_YAWP;
        else if (seen[K_YAWM]) a = ACT_YAWM;
        else if (seen[K_S])    a = ACT_SET;
        else if (seen[K_GET])  a = ACT_GET;
        else                   a = ACT_NONE;
        return a;
    endfunction

    function automatic logic [4:0] n_steps(input t_action a);
        logic [4:0] n;
        case (a)
            ACT_LOCK: n = 5'd4;
            ACT_UNL:  n = 5'd5;
            ACT_MID:  n = 5'd3;
            ACT_SET:  n = 5'd3;
            ACT_GET:  n = 5'd21;
            default:  n = 5'd1;
        endcase
        return n;
    endfunction

    // The GET reply: four digits of each channel, separators and two NULs.
    function automatic t_get_step get_step(input logic [4:0] step);
        t_get_step  g;
        logic [4:0] off;
        g.src  = RS_DIGIT;
        g.chan = CH_ROLL;
        off    = step;
        case (step) inside
            [5'd0:5'd3]:   begin g.chan = CH_ROLL;     off = step; end
            [5'd5:5'd8]:   begin g.chan = CH_PITCH;    off = step - 5'd5; end
            [5'd11:5'd14]: begin g.chan = CH_THROTTLE; off = step - 5'd11; end
            [5'd16:5'd19]: begin g.chan = CH_YAW;      off = step - 5'd16; end
            5'd4, 5'd9, 5'd15: g.src = RS_PLUS;
            default:       g.src = RS_NUL;
        endcase
        g.pos = ~off[1:0];
        return g;
    endfunction

endpackage

`default_nettype wire

>>> design/tcpwm_front.sv
`timescale 1ns / 1ps
`default_nettype none

module tcpwm_front import tcpwm_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_push,
    input  wire logic [7:0] i_rx_byte,
    input  wire logic       i_end_of_message,
    input  wire logic       i_q_full,
    output logic            o_full,
    output logic            o_q_push,
    output t_cmd            o_q_cmd
);

    logic [7:0]            r_recent [3];
    logic [KW_N-1:0]       r_seen;
    logic [CAP_N-1:0][7:0] r_cap;
    logic [POS_W-1:0]      r_pos;
    logic                  r_ended;

    logic [7:0]            n_recent [3];
    logic [KW_N-1:0]       n_seen;
    logic [CAP_N-1:0][7:0] n_cap;
    logic                  n_ended;
    logic                  accept, stored, note;
    logic [KW_N-1:0]       flags;
    logic [31:0]           win;
    t_action               act;

    assign o_full = i_q_full;
    assign accept = i_push & ~i_q_full;
    assign stored = r_pos < POS_W'(MSG_MAX);
    assign win    = {r_recent[0], r_recent[1], r_recent[2], i_rx_byte};

    always_comb begin
        for (int i = 0; i < CAP_N; i++) begin
            n_cap[i] = (stored && r_pos == POS_W'(i + 1)) ? i_rx_byte : r_cap[i];
        end
        n_ended = r_ended | (stored & (i_rx_byte == 8'd0));
        note    = stored & ~n_ended;

        flags         = '0;
        flags[K_LOCK] = win == KW_LOCK;
        flags[K_UNL]  = win[23:0] == KW_UNL;
        flags[K_MID]  = win[23:0] == KW_MID;
        flags[K_PITP] = win == KW_PITP;
        flags[K_PITM] = win == KW_PITM;
        flags[K_ROLP] = win == KW_ROLP;
        flags[K_ROLM] = win == KW_ROLM;
        flags[K_UPDP] = win == KW_UPDP;
        flags[K_UPDM] = win == KW_UPDM;
        flags[K_YAWP] = win == KW_YAWP;
        flags[K_YAWM] = win == KW_YAWM;
        flags[K_S]    = i_rx_byte == KW_S;
        flags[K_GET]  = win[23:0] == KW_GET;

        n_seen      = note ? (r_seen | flags) : r_seen;
        n_recent[0] = note ? r_recent[1] : r_recent[0];
        n_recent[1] = note ? r_recent[2] : r_recent[1];
        n_recent[2] = note ? i_rx_byte   : r_recent[2];
        act         = prio(n_seen);
    end

    assign o_q_push       = accept & i_end_of_message & (act != ACT_NONE);
    assign o_q_cmd.action = act;
    assign o_q_cmd.caps   = n_cap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (accept && i_end_of_message)) begin
            r_recent[0] <= '0;
            r_recent[1] <= '0;
            r_recent[2] <= '0;
            r_seen      <= '0;
            r_cap       <= '0;
            r_pos       <= '0;
            r_ended     <= 1'b0;
        end else if (accept) begin
            r_recent <= n_recent;
            r_seen   <= n_seen;
            r_cap    <= n_cap;
            r_ended  <= n_ended;
            if (stored) begin
                r_pos <= r_pos + POS_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

>>> design/tcpwm_cmd_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module tcpwm_cmd_fifo import tcpwm_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    output logic      o_full,
    input  wire logic i_pop,
    output t_cmd      o_cmd,
    output logic      o_empty
);

    t_cmd       r_mem [2];
    logic       r_wr, r_rd;
    logic [1:0] r_cnt;
    logic       do_push, do_pop;

    assign o_full  = r_cnt == 2'd2;
    assign o_empty = r_cnt == 2'd0;
    assign o_cmd   = r_mem[r_rd];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) r_wr <= ~r_wr;
            if (do_pop)  r_rd <= ~r_rd;
            r_cnt <= r_cnt + 2'(do_push) - 2'(do_pop);
        end
    end

endmodule

`default_nettype wire

>>> design/tcpwm_back.sv
`timescale 1ns / 1ps
`default_nettype none

module tcpwm_back import tcpwm_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        i_q_empty,
    input  wire t_cmd        i_q_cmd,
    output logic             o_q_pop,
    input  wire logic        i_pop,
    output logic             o_empty,
    output t_result          o_res
);

    typedef enum logic [1:0] {ST_IDLE = 2'b01, ST_RUN = 2'b10} t_state;

    t_state                r_state;
    t_action               r_act;
    logic [CAP_N-1:0][7:0] r_caps;
    logic [4:0]            r_step;
    logic [15:0]           r_rem;
    logic [15:0]           r_chan [4];
    logic [15:0]           r_neutral, r_floor, r_ceiling, r_fine, r_tstep, r_arm, r_disarm;
    t_result               r_out [2];
    logic                  r_owr, r_ord;
    logic [1:0]            r_ocnt;

    logic [15:0]           n_chan [4];
    logic [15:0]           n_rem;
    t_result               res;
    logic                  room, emit, last_step, load, out_pop;
    logic [15:0]           d [4];
    logic [15:0]           set_val, src, upd;
    t_get_step             ge;
    logic [32:0]           p3;
    logic [15:0]           p2;
    logic [14:0]           p1;
    logic [6:0]            q;

    assign room      = (r_ocnt != 2'd2) | i_pop;
    assign emit      = (r_state == ST_RUN) & room;
    assign last_step = r_step == n_steps(r_act) - 5'd1;
    assign load      = ((r_state == ST_IDLE) | (emit & last_step)) & ~i_q_empty;
    assign o_q_pop   = load;
    assign out_pop   = i_pop & (r_ocnt != 2'd0);
    assign o_empty   = r_ocnt == 2'd0;
    assign o_res     = r_out[r_ord];

    // Decimal load: the four captured bytes at the bottom of the shift register.
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            d[i] = 16'(r_caps[i]) - 16'(CHR_ZERO);
        end
        set_val = d[0] * 16'd1000 + d[1] * 16'd100 + d[2] * 16'd10 + d[3];
    end

    // One reply digit a beat; the remainder carries over to the next digit.
    always_comb begin
        ge  = get_step(r_step);
        src = (ge.pos == 2'd3) ? r_chan[ge.chan] : r_rem;
        p3  = 33'(src) * 33'd67109;
        p2  = 16'(src[9:0]) * 16'd41;
        p1  = 15'(src[6:0]) * 15'd205;
        case (ge.pos)
            2'd3: begin
                q     = p3[32:26];
                n_rem = src - 16'(q) * 16'd1000;
            end
            2'd2: begin
                q     = 7'(p2[15:12]);
                n_rem = src - 16'(q) * 16'd100;
            end
            2'd1: begin
                q     = 7'(p1[14:11]);
                n_rem = src - 16'(q) * 16'd10;
            end
            default: begin
                q     = 7'(src[3:0]);
                n_rem = 16'd0;
            end
        endcase
    end

    always_comb begin
        res       = '0;
        res.kind  = KIND_WRITE;
        res.last  = last_step;
        n_chan    = r_chan;
        upd       = r_chan[CH_THROTTLE];
        unique case (r_act) inside
            ACT_LOCK, ACT_UNL: begin
                n_chan[CH_ROLL]     = r_neutral;
                n_chan[CH_PITCH]    = r_neutral;
                n_chan[CH_THROTTLE] = r_floor;
                n_chan[CH_YAW]      = r_neutral;
                case (r_step)
                    5'd0: begin res.chan = CH_ROLL;     res.width = r_neutral; end
                    5'd1: begin res.chan = CH_PITCH;    res.width = r_neutral; end
                    5'd2: begin res.chan = CH_THROTTLE; res.width = r_floor;   end
                    5'd3: begin
                        res.chan  = CH_YAW;
                        res.width = (r_act == ACT_LOCK) ? r_disarm : r_neutral;
                    end
                    default: begin res.chan = CH_YAW; res.width = r_arm; end
                endcase
            end
            ACT_MID: begin
                n_chan[CH_ROLL]  = r_neutral;
                n_chan[CH_PITCH] = r_neutral;
                n_chan[CH_YAW]   = r_neutral;
                res.width        = r_neutral;
                case (r_step)
                    5'd0:    res.chan = CH_ROLL;
                    5'd1:    res.chan = CH_PITCH;
                    default: res.chan = CH_YAW;
                endcase
            end
            ACT_PITP, ACT_PITM: begin
                res.chan  = CH_PITCH;
                res.width = (r_act == ACT_PITP) ? r_chan[CH_PITCH] + r_fine
                                                : r_chan[CH_PITCH] - r_fine;
                n_chan[CH_PITCH] = res.width;
            end
            ACT_ROLP, ACT_ROLM: begin
                res.chan  = CH_ROLL;
                res.width = (r_act == ACT_ROLP) ? r_chan[CH_ROLL] + r_fine
                                                : r_chan[CH_ROLL] - r_fine;
                n_chan[CH_ROLL] = res.width;
            end
            ACT_YAWP, ACT_YAWM: begin
                res.chan  = CH_YAW;
                res.width = (r_act == ACT_YAWP) ? r_chan[CH_YAW] + r_fine
                                                : r_chan[CH_YAW] - r_fine;
                n_chan[CH_YAW] = res.width;
            end
            ACT_UPDP: begin
                if (r_chan[CH_THROTTLE] <= r_ceiling) upd = r_chan[CH_THROTTLE] + r_tstep;
                res.chan            = CH_THROTTLE;
                res.width           = upd;
                n_chan[CH_THROTTLE] = upd;
            end
            ACT_UPDM: begin
                if (r_chan[CH_THROTTLE] > r_floor) upd = r_chan[CH_THROTTLE] - r_tstep;
                res.chan            = CH_THROTTLE;
                res.width           = upd;
                n_chan[CH_THROTTLE] = upd;
            end
            ACT_SET: begin
                res.chan            = r_step[1:0];
                res.width           = set_val;
                n_chan[r_step[1:0]] = set_val;
            end
            ACT_GET: begin
                res.kind = KIND_REPLY;
                case (ge.src)
                    RS_DIGIT: res.reply = 8'(q) + CHR_ZERO;
                    RS_PLUS:  res.reply = CHR_PLUS;
                    default:  res.reply = CHR_NUL;
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_act  <= i_q_cmd.action;
            r_caps <= i_q_cmd.caps;
            r_step <= 5'd0;
        end else if (emit) begin
            r_step <= r_step + 5'd1;
            r_caps <= {32'd0, r_caps[CAP_N-1:4]};
        end
        if (emit && r_act == ACT_GET && ge.src == RS_DIGIT) begin
            r_rem <= n_rem;
        end
        if (emit) begin
            r_out[r_owr] <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_owr     <= 1'b0;
            r_ord     <= 1'b0;
            r_ocnt    <= 2'd0;
            r_chan[CH_ROLL]     <= RST_NEUTRAL;
            r_chan[CH_PITCH]    <= RST_NEUTRAL;
            r_chan[CH_THROTTLE] <= RST_FLOOR;
            r_chan[CH_YAW]      <= RST_NEUTRAL;
            r_neutral <= RST_NEUTRAL;
            r_floor   <= RST_FLOOR;
            r_ceiling <= RST_CEILING;
            r_fine    <= RST_FINE;
            r_tstep   <= RST_TSTEP;
            r_arm     <= RST_ARM;
            r_disarm  <= RST_DISARM;
        end else begin
            if (load) begin
                r_state <= ST_RUN;
            end else if (emit && last_step) begin
                r_state <= ST_IDLE;
            end
            if (emit) begin
                r_chan <= n_chan;
                r_owr  <= ~r_owr;
            end
            if (out_pop) r_ord <= ~r_ord;
            r_ocnt <= r_ocnt + 2'(emit) - 2'(out_pop);
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_NEUTRAL: r_neutral <= i_cfg_data;
                    CFG_FLOOR:   r_floor   <= i_cfg_data;
                    CFG_CEILING: r_ceiling <= i_cfg_data;
                    CFG_FINE:    r_fine    <= i_cfg_data;
                    CFG_TSTEP:   r_tstep   <= i_cfg_data;
                    CFG_ARM:     r_arm     <= i_cfg_data;
                    CFG_DISARM:  r_disarm  <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

endmodule

`default_nettype wire

>>> design/text_command_pwm_channel_setter.sv
// Channel   Handshake              Beat carries
// input     i_push / o_full        i_rx_byte, i_end_of_message
// result    o_empty / i_pop        o_result_kind, o_channel_index, o_pulse_width,
//                                  o_reply_byte, o_last_of_run
// config    i_cfg_we               i_cfg_index, i_cfg_data
//
// One byte is accepted per cycle; the parser keeps no state that costs extra cycles.
// A finished message enters a two-entry command queue; the executor then gives one
// result a cycle while its queue has room (4, 5, 3, 1 or 3 writes, or 21 GET bytes).
// Input stalls only when the command queue is full; results sit in a two-entry queue.
// Synchronous active-low reset restores the configuration registers and the channel widths.
`timescale 1ns / 1ps
`default_nettype none

module text_command_pwm_channel_setter import tcpwm_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    output logic             o_full,
    input  wire logic [7:0]  i_rx_byte,
    input  wire logic        i_end_of_message,
    output logic             o_empty,
    input  wire logic        i_pop,
    output logic             o_result_kind,
    output logic [1:0]       o_channel_index,
    output logic [15:0]      o_pulse_width,
    output logic [7:0]       o_reply_byte,
    output logic             o_last_of_run,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    logic    q_push, q_full, q_pop, q_empty;
    t_cmd    q_in, q_out;
    t_result res;

    tcpwm_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (i_push),
        .i_rx_byte        (i_rx_byte),
        .i_end_of_message (i_end_of_message),
        .i_q_full         (q_full),
        .o_full           (o_full),
        .o_q_push         (q_push),
        .o_q_cmd          (q_in)
    );

    tcpwm_cmd_fifo u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_cmd   (q_out),
        .o_empty (q_empty)
    );

    tcpwm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_empty   (q_empty),
        .i_q_cmd     (q_out),
        .o_q_pop     (q_pop),
        .i_pop       (i_pop),
        .o_empty     (o_empty),
        .o_res       (res)
    );

    assign o_result_kind   = res.kind;
    assign o_channel_index = res.chan;
    assign o_pulse_width   = res.width;
    assign o_reply_byte    = res.reply;
    assign o_last_of_run   = res.last;

endmodule

`default_nettype wire

>>> design/tcpwm_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module tcpwm_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_empty,
    input wire logic        i_pop,
    input wire logic        o_result_kind,
    input wire logic [1:0]  o_channel_index,
    input wire logic [15:0] o_pulse_width,
    input wire logic [7:0]  o_reply_byte
);

    a_empty_after_reset: assert property (@(posedge i_clk) !i_rst_n |=> o_empty)
        else $error("result queue not empty after reset");

    a_reply_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty && o_result_kind |-> o_channel_index == 2'd0 && o_pulse_width == 16'd0)
        else $error("reply beat carries a channel write");

    a_write_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty && !o_result_kind |-> o_reply_byte == 8'd0)
        else $error("write beat carries a reply byte");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty && !i_pop |=> !o_empty)
        else $error("waiting result beat withdrawn");

endmodule

bind text_command_pwm_channel_setter tcpwm_checker u_chk (.*);

`default_nettype wire
